/* src/evss_pkg.sv */
// Shared types, register codes and constants of the energy speech segmenter.
`timescale 1ns / 1ps
`default_nettype none

package evss_pkg;

	localparam int ENERGY_W   = 43;
	localparam int CNT_W      = 20;
	localparam int FS_W       = 13;
	localparam int SPEECH_W   = 8;
	localparam int SILENCE_W  = 10;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = ENERGY_W;
	localparam int OUT_W      = 32;

	localparam logic [ENERGY_W-1:0]  ENERGY_MAX  = {ENERGY_W{1'b1}};
	localparam logic [SPEECH_W-1:0]  SPEECH_MAX  = {SPEECH_W{1'b1}};
	localparam logic [SILENCE_W-1:0] SILENCE_MAX = {SILENCE_W{1'b1}};

	localparam logic [ENERGY_W-1:0] RST_ENERGY_THRESHOLD = 43'd11601243;
	localparam logic [FS_W-1:0]     RST_FRAME_SAMPLES    = 13'd882;
	localparam logic [SPEECH_W-1:0] RST_START_FRAMES     = 8'd3;
	localparam logic [SILENCE_W-1:0] RST_END_SILENCE     = 10'd30;
	localparam logic [CNT_W-1:0]    RST_TAIL_SAMPLES     = 20'd8820;
	localparam logic [CNT_W-1:0]    RST_PRESPEECH_LIMIT  = 20'd8820;
	localparam logic [CNT_W-1:0]    RST_MIN_SAMPLES      = 20'd13230;
	localparam logic [CNT_W-1:0]    RST_MAX_SAMPLES      = 20'd441000;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_ENERGY_THRESHOLD = 3'd0,
		REG_FRAME_SAMPLES    = 3'd1,
		REG_START_FRAMES     = 3'd2,
		REG_END_SILENCE      = 3'd3,
		REG_TAIL_SAMPLES     = 3'd4,
		REG_PRESPEECH_LIMIT  = 3'd5,
		REG_MIN_SAMPLES      = 3'd6,
		REG_MAX_SAMPLES      = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ROUTE_DISCARD   = 2'd0,
		ROUTE_PRESPEECH = 2'd1,
		ROUTE_BODY      = 2'd2,
		ROUTE_TAIL      = 2'd3
	} route_t;

	typedef enum logic [1:0] {
		EV_NONE     = 2'd0,
		EV_STARTED  = 2'd1,
		EV_ACCEPTED = 2'd2,
		EV_DROPPED  = 2'd3
	} event_t;

	typedef enum logic {
		ST_IDLE     = 1'b0,
		ST_SPEAKING = 1'b1
	} seg_state_t;

	typedef struct packed {
		logic [ENERGY_W-1:0]  energy_threshold;
		logic [FS_W-1:0]      frame_samples;
		logic [SPEECH_W-1:0]  start_frames;
		logic [SILENCE_W-1:0] end_silence_frames;
		logic [CNT_W-1:0]     tail_samples;
		logic [CNT_W-1:0]     prespeech_limit;
		logic [CNT_W-1:0]     min_samples;
		logic [CNT_W-1:0]     max_samples;
	} cfg_t;

	// Finished frame handed from the accumulator to the segmenter.
	typedef struct packed {
		logic                valid;
		logic [ENERGY_W-1:0] energy;
	} frame_t;

	typedef struct packed {
		logic             silent_status;
		logic [CNT_W-1:0] segment_length;
		event_t           segment_event;
		route_t           frame_route;
		logic             frame_silent;
	} result_t;

	// Add n to count, saturating at cap; a count already at the cap holds.
	function automatic logic [CNT_W-1:0] add_capped(
		input logic [CNT_W-1:0] count,
		input logic [CNT_W-1:0] n,
		input logic [CNT_W-1:0] cap
	);
		logic [CNT_W:0] sum;
		sum = {1'b0, count} + {1'b0, n};
		if (count >= cap)
			return count;
		else if (sum > {1'b0, cap})
			return cap;
		else
			return sum[CNT_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* src/evss_energy.sv */
// Sample input register, squarer and frame energy accumulator.
`timescale 1ns / 1ps
`default_nettype none

module evss_energy #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int FRAME_LIMIT  = 4096
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [SAMPLE_WIDTH-1:0]        sample_value,
	input  wire logic [$clog2(FRAME_LIMIT):0]   flen,
	output evss_pkg::frame_t                    frame,
	input  wire logic                           frame_take
);
	import evss_pkg::*;

	localparam int PW    = $clog2(FRAME_LIMIT);
	localparam int SQ_W  = 2 * SAMPLE_WIDTH;
	localparam int SUM_W = ((SQ_W > ENERGY_W) ? SQ_W : ENERGY_W) + 1;

	logic                    v_s1;
	logic [SAMPLE_WIDTH-1:0] sample_s1;
	logic                    v_s2;
	logic [SQ_W-1:0]         sq_s2;
	logic                    v_s3;
	logic [ENERGY_W-1:0]     energy_s3;

	logic [ENERGY_W-1:0] energy_q;
	logic [PW-1:0]       pos_q;

	logic [SAMPLE_WIDTH-1:0] mag;
	logic [SUM_W-1:0]        sum_wide;
	logic [ENERGY_W-1:0]     sum_sat;
	logic [PW:0]             pos_next;
	logic                    frame_end;
	logic                    en_s3, cons_s2, en_s2;

	// Magnitude of the most negative code is 2^(W-1), still fits unsigned.
	assign mag = sample_s1[SAMPLE_WIDTH-1] ? (~sample_s1 + 1'b1) : sample_s1;

	assign sum_wide  = SUM_W'(energy_q) + SUM_W'(sq_s2);
	assign sum_sat   = (sum_wide > SUM_W'(ENERGY_MAX)) ? ENERGY_MAX : sum_wide[ENERGY_W-1:0];
	assign pos_next  = (PW + 1)'(pos_q) + 1'b1;
	assign frame_end = (pos_next >= flen);

	assign en_s3    = !v_s3 || frame_take;
	assign cons_s2  = v_s2 && (!frame_end || en_s3);
	assign en_s2    = !v_s2 || cons_s2;
	assign in_ready = !v_s1 || en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (in_ready)
				v_s1 <= in_valid;
			if (en_s2)
				v_s2 <= v_s1;
			if (en_s3)
				v_s3 <= cons_s2 && frame_end;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			sample_s1 <= sample_value;
		if (v_s1 && en_s2)
			sq_s2 <= SQ_W'(mag) * SQ_W'(mag);
		if (cons_s2 && frame_end)
			energy_s3 <= sum_sat;
	end

	// Running frame state: clear at frame end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q <= '0;
			pos_q    <= '0;
		end else if (cons_s2) begin
			energy_q <= frame_end ? '0 : sum_sat;
			pos_q    <= frame_end ? '0 : pos_next[PW-1:0];
		end
	end

	assign frame.valid  = v_s3;
	assign frame.energy = energy_s3;

endmodule

`default_nettype wire

/* src/evss_seg.sv */
// Frame classifier, idle/speaking segmenter and result register.
`timescale 1ns / 1ps
`default_nettype none

module evss_seg (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire evss_pkg::cfg_t          cfg,
	input  wire logic [19:0]             flen,
	input  wire evss_pkg::frame_t        frame,
	output logic                         frame_take,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output evss_pkg::result_t            result
);
	import evss_pkg::*;

	seg_state_t           state_q, state_d;
	logic [SPEECH_W-1:0]  speech_q, speech_d;
	logic [SILENCE_W-1:0] silence_q, silence_d;
	logic [CNT_W-1:0]     pre_q, pre_d;
	logic [CNT_W-1:0]     seg_q, seg_d;
	logic [CNT_W-1:0]     tail_q, tail_d;
	logic                 out_v_q;
	result_t              res_q, res_d;
	logic                 silent;
	logic [CNT_W-1:0]     closed;

	assign frame_take = frame.valid && (!out_v_q || out_ready);
	assign silent     = frame.energy < cfg.energy_threshold;

	always_comb begin
		state_d   = state_q;
		speech_d  = speech_q;
		silence_d = silence_q;
		pre_d     = pre_q;
		seg_d     = seg_q;
		tail_d    = tail_q;
		closed    = add_capped(seg_q, add_capped(tail_q, flen, cfg.tail_samples),
			cfg.max_samples);
		res_d.frame_silent   = silent;
		res_d.frame_route    = ROUTE_DISCARD;
		res_d.segment_event  = EV_NONE;
		res_d.segment_length = '0;
		res_d.silent_status  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (silent) begin
					speech_d = '0;
					pre_d    = '0;
					res_d.silent_status = 1'b1;
				end else begin
					if (speech_q != SPEECH_MAX)
						speech_d = speech_q + 1'b1;
					pre_d = add_capped(pre_q, flen, cfg.prespeech_limit);
					res_d.frame_route = ROUTE_PRESPEECH;
					if (speech_d >= cfg.start_frames) begin
						state_d   = ST_SPEAKING;
						silence_d = '0;
						tail_d    = '0;
						seg_d     = add_capped('0, pre_d, cfg.max_samples);
						pre_d     = '0;
						res_d.segment_event = EV_STARTED;
					end
				end
			end
			ST_SPEAKING: begin
				if (!silent) begin
					silence_d = '0;
					tail_d    = '0;
					seg_d     = add_capped(seg_q, flen, cfg.max_samples);
					res_d.frame_route = ROUTE_BODY;
				end else begin
					if (silence_q != SILENCE_MAX)
						silence_d = silence_q + 1'b1;
					tail_d = add_capped(tail_q, flen, cfg.tail_samples);
					res_d.frame_route = ROUTE_TAIL;
					if (silence_d >= cfg.end_silence_frames) begin
						// Close: fold the capped tail in and judge the length.
						res_d.segment_length = closed;
						if (closed < cfg.min_samples || closed > cfg.max_samples ||
							closed == '0)
							res_d.segment_event = EV_DROPPED;
						else
							res_d.segment_event = EV_ACCEPTED;
						state_d   = ST_IDLE;
						tail_d    = '0;
						seg_d     = '0;
						silence_d = '0;
						speech_d  = '0;
						res_d.silent_status = 1'b1;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			speech_q  <= '0;
			silence_q <= '0;
			pre_q     <= '0;
			seg_q     <= '0;
			tail_q    <= '0;
		end else if (frame_take) begin
			state_q   <= state_d;
			speech_q  <= speech_d;
			silence_q <= silence_d;
			pre_q     <= pre_d;
			seg_q     <= seg_d;
			tail_q    <= tail_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (!out_v_q || out_ready)
			out_v_q <= frame.valid;
	end

	always_ff @(posedge clk) begin
		if (frame_take)
			res_q <= res_d;
	end

	assign out_valid = out_v_q;
	assign result    = res_q;

endmodule

`default_nettype wire

/* src/energy_vad_speech_segmenter.sv */
// Top level of the energy-based voice activity detector and speech segmenter.
`timescale 1ns / 1ps
`default_nettype none

// Energy VAD speech segmenter. Takes one signed Q15 sample per transfer on the
// s_axis side and sustains one sample per clock. Each sample is squared and
// added into a saturating 43-bit frame energy; after frame_samples samples
// (zero acts as one, values above FRAME_LIMIT act as FRAME_LIMIT) the frame
// is classified silent when its energy is below energy_threshold, and an
// idle/speaking machine routes it (discarded, pre-speech, body or tail) and
// reports segment start, accept or drop with the closed segment length.
// Exactly one result transfer leaves on m_axis per frame, once the frame's
// last sample has passed the pipeline; samples that do not end a frame
// produce nothing. The pipeline is input register, squarer, accumulator and
// result register; each stage holds its item independently, so input keeps
// flowing while a result waits, until two more frames have ended behind it.
// Configuration registers are written through cfg_wen/cfg_addr/cfg_wdata and
// must only change while the block is drained. No clearing pass after reset.
module energy_vad_speech_segmenter #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int FRAME_LIMIT  = 4096
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// [SAMPLE_WIDTH-1:0] sample_value, rest zero pad
	input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// [0] frame_silent, [2:1] frame_route, [4:3] segment_event,
	// [24:5] segment_length, [25] silent_status, [31:26] zero
	output logic [evss_pkg::OUT_W-1:0]              m_axis_tdata,
	input  wire logic                               cfg_wen,
	input  wire logic [evss_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  wire logic [evss_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import evss_pkg::*;

	localparam int PW = $clog2(FRAME_LIMIT);
	localparam int RES_W = $bits(result_t);

	cfg_t           cfg_q;
	logic [PW:0]    flen;
	frame_t         frame;
	logic           frame_take;
	result_t        result;

	// Register file: hold every value until rewritten.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.energy_threshold   <= RST_ENERGY_THRESHOLD;
			cfg_q.frame_samples      <= RST_FRAME_SAMPLES;
			cfg_q.start_frames       <= RST_START_FRAMES;
			cfg_q.end_silence_frames <= RST_END_SILENCE;
			cfg_q.tail_samples       <= RST_TAIL_SAMPLES;
			cfg_q.prespeech_limit    <= RST_PRESPEECH_LIMIT;
			cfg_q.min_samples        <= RST_MIN_SAMPLES;
			cfg_q.max_samples        <= RST_MAX_SAMPLES;
		end else if (cfg_wen) begin
			unique case (cfg_idx_t'(cfg_addr))
				REG_ENERGY_THRESHOLD: cfg_q.energy_threshold   <= cfg_wdata;
				REG_FRAME_SAMPLES:    cfg_q.frame_samples      <= cfg_wdata[FS_W-1:0];
				REG_START_FRAMES:     cfg_q.start_frames       <= cfg_wdata[SPEECH_W-1:0];
				REG_END_SILENCE:      cfg_q.end_silence_frames <= cfg_wdata[SILENCE_W-1:0];
				REG_TAIL_SAMPLES:     cfg_q.tail_samples       <= cfg_wdata[CNT_W-1:0];
				REG_PRESPEECH_LIMIT:  cfg_q.prespeech_limit    <= cfg_wdata[CNT_W-1:0];
				REG_MIN_SAMPLES:      cfg_q.min_samples        <= cfg_wdata[CNT_W-1:0];
				REG_MAX_SAMPLES:      cfg_q.max_samples        <= cfg_wdata[CNT_W-1:0];
			endcase
		end
	end

	// Effective frame length: clamp zero up to one and large values to the limit.
	always_comb begin
		if (cfg_q.frame_samples == '0)
			flen = (PW + 1)'(1);
		else if (32'(cfg_q.frame_samples) > FRAME_LIMIT)
			flen = (PW + 1)'(FRAME_LIMIT);
		else
			flen = (PW + 1)'(cfg_q.frame_samples);
	end

	evss_energy #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.FRAME_LIMIT  (FRAME_LIMIT)
	) u_energy (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.sample_value (s_axis_tdata[SAMPLE_WIDTH-1:0]),
		.flen         (flen),
		.frame        (frame),
		.frame_take   (frame_take)
	);

	evss_seg u_seg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.flen       (CNT_W'(flen)),
		.frame      (frame),
		.frame_take (frame_take),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.result     (result)
	);

	assign m_axis_tdata = {(OUT_W - RES_W)'(0), result};

endmodule

`default_nettype wire

/* src/evss_checker.sv */
// Port-level checks of the segmenter results, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module evss_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata
);
	import evss_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[24:5] != 20'd0 |->
		m_axis_tdata[4:3] == EV_ACCEPTED || m_axis_tdata[4:3] == EV_DROPPED)
		else $error("segment length without a closing event");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[4:3] == EV_STARTED |->
		m_axis_tdata[2:1] == ROUTE_PRESPEECH && !m_axis_tdata[0])
		else $error("speech start on a frame that is not voiced pre-speech");

	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[4:3] == EV_ACCEPTED ||
		m_axis_tdata[4:3] == EV_DROPPED) |->
		m_axis_tdata[2:1] == ROUTE_TAIL && m_axis_tdata[25] && m_axis_tdata[0])
		else $error("segment closed outside a silent tail frame");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[25] |-> m_axis_tdata[0])
		else $error("silence status on a voiced frame");

endmodule

bind energy_vad_speech_segmenter evss_checker u_evss_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* tb/sv/segment_result_checker.sv */
// Checker that predicts the segmenter's per-frame results and compares them on the output.
`timescale 1ns / 1ps

module segment_result_checker #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int FRAME_LIMIT  = 4096
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	input  logic                                   s_axis_tready,
	// [SAMPLE_WIDTH-1:0] sample_value, rest zero pad
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
	input  logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// [0] frame_silent, [2:1] frame_route, [4:3] segment_event,
	// [24:5] segment_length, [25] silent_status, [31:26] zero
	input  logic [evss_pkg::OUT_W-1:0]             m_axis_tdata,
	input  logic                                   cfg_wen,
	input  logic [evss_pkg::CFG_ADDR_W-1:0]        cfg_addr,
	input  logic [evss_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	output int                                     outstanding,
	output int                                     fail_count
);
	import evss_pkg::*;

	localparam int RES_W     = $bits(result_t);

	cfg_t                 regs;
	seg_state_t           seg_state;
	logic [ENERGY_W-1:0]  frame_energy;
	int unsigned          frame_pos;
	logic [SPEECH_W-1:0]  voiced_run;
	logic [SILENCE_W-1:0] silent_run;
	logic [CNT_W-1:0]     prespeech_len;
	logic [CNT_W-1:0]     segment_len;
	logic [CNT_W-1:0]     tail_len;
	result_t              frame_results [$];
	int                   mismatches = 0;

	function automatic logic [CNT_W-1:0] capped_sum(
		input logic [CNT_W-1:0] count,
		input logic [CNT_W-1:0] n,
		input logic [CNT_W-1:0] cap
	);
		if (count >= cap)
			return count;
		if (n > cap - count)
			return cap;
		return count + n;
	endfunction

	task automatic log_mismatch(input string what);
		mismatches++;
		$display("%0t ns: segmenter result mismatch: %s", $realtime, what);
	endtask

	// Add one sample to the running frame; at a frame end, queue the frame's result.
	task automatic absorb_sample(input logic [SAMPLE_WIDTH-1:0] raw);
		logic [SAMPLE_WIDTH:0] mag;
		logic [ENERGY_W:0]     acc;
		logic [CNT_W-1:0]      flen;
		logic                  silent;
		result_t               res;
		mag = raw[SAMPLE_WIDTH-1] ? -{1'b1, raw} : {1'b0, raw};
		acc = {1'b0, frame_energy} + mag * mag;
		frame_energy = acc[ENERGY_W] ? ENERGY_MAX : acc[ENERGY_W-1:0];
		if (regs.frame_samples == '0)
			flen = CNT_W'(1);
		else if (regs.frame_samples > FRAME_LIMIT)
			flen = CNT_W'(FRAME_LIMIT);
		else
			flen = CNT_W'(regs.frame_samples);
		frame_pos++;
		if (frame_pos < flen)
			return;

		silent = frame_energy < regs.energy_threshold;
		frame_energy = '0;
		frame_pos = 0;
		res = '0;
		res.frame_silent = silent;
		res.frame_route = ROUTE_DISCARD;
		res.segment_event = EV_NONE;

		if (seg_state == ST_IDLE) begin
			if (silent) begin
				voiced_run = '0;
				prespeech_len = '0;
				res.silent_status = 1'b1;
			end else begin
				if (voiced_run != SPEECH_MAX)
					voiced_run = voiced_run + 1'b1;
				prespeech_len = capped_sum(prespeech_len, flen, regs.prespeech_limit);
				res.frame_route = ROUTE_PRESPEECH;
				if (voiced_run >= regs.start_frames) begin
					seg_state = ST_SPEAKING;
					silent_run = '0;
					tail_len = '0;
					segment_len = capped_sum('0, prespeech_len, regs.max_samples);
					prespeech_len = '0;
					res.segment_event = EV_STARTED;
				end
			end
		end else if (!silent) begin
			silent_run = '0;
			tail_len = '0;
			segment_len = capped_sum(segment_len, flen, regs.max_samples);
			res.frame_route = ROUTE_BODY;
		end else begin
			if (silent_run != SILENCE_MAX)
				silent_run = silent_run + 1'b1;
			tail_len = capped_sum(tail_len, flen, regs.tail_samples);
			res.frame_route = ROUTE_TAIL;
			if (silent_run >= regs.end_silence_frames) begin
				segment_len = capped_sum(segment_len, tail_len, regs.max_samples);
				res.segment_length = segment_len;
				if (segment_len == '0 || segment_len < regs.min_samples ||
						segment_len > regs.max_samples)
					res.segment_event = EV_DROPPED;
				else
					res.segment_event = EV_ACCEPTED;
				tail_len = '0;
				segment_len = '0;
				seg_state = ST_IDLE;
				silent_run = '0;
				voiced_run = '0;
				res.silent_status = 1'b1;
			end
		end
		frame_results.insert(frame_results.size(), res);
	endtask

	task automatic check_result(input logic [OUT_W-1:0] word);
		result_t want;
		result_t got;
		if (frame_results.size() == 0) begin
			log_mismatch($sformatf("result 0x%08h arrived with no frame pending", word));
			return;
		end
		want = frame_results[0];
		frame_results.delete(0);
		got = result_t'(word[RES_W-1:0]);
		if (got.frame_silent !== want.frame_silent)
			log_mismatch($sformatf("frame_silent %0b, expected %0b",
				got.frame_silent, want.frame_silent));
		if (got.frame_route !== want.frame_route)
			log_mismatch($sformatf("frame_route %0d, expected %0d",
				got.frame_route, want.frame_route));
		if (got.segment_event !== want.segment_event)
			log_mismatch($sformatf("segment_event %0d, expected %0d",
				got.segment_event, want.segment_event));
		if (got.segment_length !== want.segment_length)
			log_mismatch($sformatf("segment_length %0d, expected %0d",
				got.segment_length, want.segment_length));
		if (got.silent_status !== want.silent_status)
			log_mismatch($sformatf("silent_status %0b, expected %0b",
				got.silent_status, want.silent_status));
		if (word[OUT_W-1:RES_W] !== '0)
			log_mismatch($sformatf("pad bits 0x%0h, expected zero", word[OUT_W-1:RES_W]));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '{RST_ENERGY_THRESHOLD, RST_FRAME_SAMPLES, RST_START_FRAMES,
				RST_END_SILENCE, RST_TAIL_SAMPLES, RST_PRESPEECH_LIMIT,
				RST_MIN_SAMPLES, RST_MAX_SAMPLES};
			seg_state = ST_IDLE;
			frame_energy = '0;
			frame_pos = 0;
			voiced_run = '0;
			silent_run = '0;
			prespeech_len = '0;
			segment_len = '0;
			tail_len = '0;
			frame_results.delete();
		end else begin
			if (cfg_wen) begin
				case (cfg_idx_t'(cfg_addr))
					REG_ENERGY_THRESHOLD: regs.energy_threshold = cfg_wdata[ENERGY_W-1:0];
					REG_FRAME_SAMPLES:    regs.frame_samples = cfg_wdata[FS_W-1:0];
					REG_START_FRAMES:     regs.start_frames = cfg_wdata[SPEECH_W-1:0];
					REG_END_SILENCE:      regs.end_silence_frames = cfg_wdata[SILENCE_W-1:0];
					REG_TAIL_SAMPLES:     regs.tail_samples = cfg_wdata[CNT_W-1:0];
					REG_PRESPEECH_LIMIT:  regs.prespeech_limit = cfg_wdata[CNT_W-1:0];
					REG_MIN_SAMPLES:      regs.min_samples = cfg_wdata[CNT_W-1:0];
					REG_MAX_SAMPLES:      regs.max_samples = cfg_wdata[CNT_W-1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				absorb_sample(s_axis_tdata[SAMPLE_WIDTH-1:0]);
			if (m_axis_tvalid && m_axis_tready)
				check_result(m_axis_tdata);
		end
		outstanding <= frame_results.size();
		fail_count <= mismatches;
	end

endmodule

/* tb/sv/testbench.sv */
// Regression top for the energy VAD speech segmenter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
	import evss_pkg::*;

	localparam int SAMPLE_WIDTH   = 16;
	localparam int FRAME_LIMIT    = 4096;
	localparam int TDATA_W        = ((SAMPLE_WIDTH+7)/8)*8;
	// Result leaves once the frame's last sample has passed the pipeline; leave margin.
	localparam int DRAIN_CYCLES   = 12;
	// Cycles the receiver refuses results during the back-pressure test.
	localparam int HOLDOFF_CYCLES = 300;
	// Cycles without any transfer or register write before the run is declared hung.
	localparam int STALL_LIMIT    = 3000;
	// Per-sample energy scale used to put the threshold between quiet and loud frames.
	localparam int LOUD_SHIFT     = 20;

	// Kinds of synthetic audio: near-silence, speech-level, and full-range noise.
	typedef enum {TONE_QUIET, TONE_LOUD, TONE_NOISE} tone_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	// [15:0] sample_value
	logic [TDATA_W-1:0]      s_axis_tdata = '0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	// [0] frame_silent, [2:1] frame_route, [4:3] segment_event,
	// [24:5] segment_length, [25] silent_status, [31:26] zero
	logic [OUT_W-1:0]        m_axis_tdata;
	logic                    cfg_wen = 1'b0;
	logic [CFG_ADDR_W-1:0]   cfg_addr = '0;
	logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

	int outstanding;
	int fail_count;
	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int holdoff_seq = 0;
	int samples_sent = 0;
	int idle_cycles = 0;

	// Hand-picked samples: both full-scale extremes, zero, minus one, and
	// alternating bit patterns around the directed threshold of 2^30.
	logic [SAMPLE_WIDTH-1:0] corner_samples [$] = '{
		16'h7FFF, 16'h8000, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
		16'h8000, 16'h8000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8000,
		16'h0000, 16'h0000, 16'h5555, 16'hAAAA, 16'h8001, 16'h4000
	};

	energy_vad_speech_segmenter #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.FRAME_LIMIT (FRAME_LIMIT)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_wen      (cfg_wen),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata)
	);

	segment_result_checker #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.FRAME_LIMIT (FRAME_LIMIT)
	) results (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_wen      (cfg_wen),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.outstanding  (outstanding),
		.fail_count   (fail_count)
	);

	always #2 clk = ~clk;

	// Watchdog: count cycles with no transfer on either side and no register
	// write; a hung block ends the run here.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wen)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("energy_vad_speech_segmenter regression: fail");
			$finish;
		end
	end

	// Result receiver. Stall at the current rate, or, when the stimulus bumps
	// holdoff_seq, refuse everything for a long stretch so the pipeline fills
	// and the block has to stall its input.
	initial begin : result_sink
		int seen;
		seen = 0;
		forever begin
			@(posedge clk);
			if (holdoff_seq != seen) begin
				seen = holdoff_seq;
				m_axis_tready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
			end
		end
	end

	function automatic cfg_t settings(
		input longint unsigned thr,
		input int fs, input int start, input int endsil,
		input int tail, input int pre, input int min_len, input int max_len
	);
		cfg_t c;
		c.energy_threshold   = thr[ENERGY_W-1:0];
		c.frame_samples      = fs[FS_W-1:0];
		c.start_frames       = start[SPEECH_W-1:0];
		c.end_silence_frames = endsil[SILENCE_W-1:0];
		c.tail_samples       = tail[CNT_W-1:0];
		c.prespeech_limit    = pre[CNT_W-1:0];
		c.min_samples        = min_len[CNT_W-1:0];
		c.max_samples        = max_len[CNT_W-1:0];
		return c;
	endfunction

	function automatic logic [SAMPLE_WIDTH-1:0] tone_sample(input tone_t tone);
		int level;
		case (tone)
			TONE_QUIET: level = int'($urandom_range(30)) - 15;
			TONE_LOUD: begin
				level = $urandom_range(32767, 8192);
				if ($urandom_range(1) == 1)
					level = -level;
				// Full negative scale now and then: the largest square there is.
				if ($urandom_range(15) == 0)
					level = -32768;
			end
			default: level = $urandom();
		endcase
		return level[SAMPLE_WIDTH-1:0];
	endfunction

	// One sample transfer. Drop valid for a random number of cycles first,
	// then offer the sample and hold it until tready is seen at an edge.
	// Valid stays high across back-to-back samples.
	task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] value);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= TDATA_W'(value);
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		samples_sent++;
	endtask

	task automatic send_frames(input tone_t tone, input int frames, input int flen);
		repeat (frames * flen)
			send_sample(tone_sample(tone));
	endtask

	// One utterance shaped for the segment machine: mostly lead-in silence,
	// a voiced run long enough to open a segment (sometimes with a short
	// pause inside), then enough silence to close it. The rest is noise, and
	// false starts too short to open a segment by themselves.
	task automatic utter(input int flen, input int start, input int endsil);
		int pick;
		pick = $urandom_range(99);
		if (pick < 12) begin
			send_frames(TONE_NOISE, $urandom_range(3, 1), flen);
		end else if (pick < 22) begin
			if (start > 1)
				send_frames(TONE_LOUD, $urandom_range(start - 1, 1), flen);
			send_frames(TONE_QUIET, $urandom_range(2, 1), flen);
		end else begin
			send_frames(TONE_QUIET, $urandom_range(2), flen);
			send_frames(TONE_LOUD, start + $urandom_range(3), flen);
			if ($urandom_range(3) == 0 && endsil > 1) begin
				// A pause shorter than the hangover stays inside the segment.
				send_frames(TONE_QUIET, $urandom_range(endsil - 1, 1), flen);
				send_frames(TONE_LOUD, $urandom_range(3, 1), flen);
			end
			send_frames(TONE_QUIET, endsil + $urandom_range(2), flen);
		end
	endtask

	task automatic run_utterances(input int count, input int flen, input int start,
			input int endsil);
		int goal;
		goal = samples_sent + count;
		while (samples_sent < goal)
			utter(flen, start, endsil);
	endtask

	// Stop offering samples, wait for every pending frame result, then let the
	// pipeline run dry: a partial frame's last sample may still be in flight.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	// Write all eight registers on consecutive edges once the block is idle.
	task automatic program_regs(input cfg_t c);
		cfg_idx_t idx;
		settle();
		idx = idx.first();
		do begin
			cfg_addr <= idx;
			case (idx)
				REG_ENERGY_THRESHOLD: cfg_wdata <= c.energy_threshold;
				REG_FRAME_SAMPLES:    cfg_wdata <= CFG_DATA_W'(c.frame_samples);
				REG_START_FRAMES:     cfg_wdata <= CFG_DATA_W'(c.start_frames);
				REG_END_SILENCE:      cfg_wdata <= CFG_DATA_W'(c.end_silence_frames);
				REG_TAIL_SAMPLES:     cfg_wdata <= CFG_DATA_W'(c.tail_samples);
				REG_PRESPEECH_LIMIT:  cfg_wdata <= CFG_DATA_W'(c.prespeech_limit);
				REG_MIN_SAMPLES:      cfg_wdata <= CFG_DATA_W'(c.min_samples);
				REG_MAX_SAMPLES:      cfg_wdata <= CFG_DATA_W'(c.max_samples);
				default:              cfg_wdata <= '0;
			endcase
			cfg_wen <= 1'b1;
			@(posedge clk);
			idx = idx.next();
		end while (idx != idx.first());
		cfg_wen <= 1'b0;
	endtask

	initial begin : stimulus
		int flen;
		int start;
		int endsil;
		longint unsigned thr;

		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a few samples of an 882-sample frame under the reset
		// settings, then shrink the frame to one sample (zero acts as one) so
		// the stretched frame ends on the next sample.
		repeat (5)
			send_sample(tone_sample(TONE_LOUD));
		program_regs(settings(longint'(1) << 30, 0, 2, 2, 1, 0, 3, 5));
		// Threshold of 2^30: only full negative scale is voiced. Walk a segment
		// through start, a tail swallowed by speech, body saturation at the
		// maximum, acceptance, then a short one that gets dropped.
		foreach (corner_samples[i])
			send_sample(corner_samples[i]);

		// Short frames, moderate limits, no idling.
		src_idle_pct = 0;
		snk_stall_pct = 0;
		program_regs(settings(4 << LOUD_SHIFT, 4, 2, 3, 6, 100, 10, 1000));
		run_utterances(250, 4, 2, 3);

		// One-sample frames with zero tail, pre-speech and maximum: every
		// segment closes empty and is dropped. Hold off the receiver meanwhile
		// so the pipeline backs up into the input.
		program_regs(settings(1 << LOUD_SHIFT, 1, 1, 1, 0, 0, 0, 0));
		holdoff_seq++;
		run_utterances(200, 1, 1, 1);

		// Largest counts: nothing ever reaches the minimum length.
		src_idle_pct = 81;
		snk_stall_pct = 0;
		program_regs(settings(8 << LOUD_SHIFT, 8, 3, 4, 1048575, 1048575, 1048575, 1048575));
		run_utterances(250, 8, 3, 4);

		// Segment count capped at one sample; tiny pre-speech and tail caps.
		src_idle_pct = 0;
		snk_stall_pct = 81;
		program_regs(settings(3 << LOUD_SHIFT, 3, 4, 2, 2, 5, 1, 1));
		run_utterances(200, 3, 4, 2);

		// Zero start and end counts: the first voiced frame opens a segment and
		// the first silent one closes it.
		src_idle_pct = 34;
		snk_stall_pct = 34;
		program_regs(settings(2 << LOUD_SHIFT, 2, 0, 0, 3, 2, 4, 50));
		run_utterances(200, 2, 0, 0);

		// Zero threshold: no frame can be silent.
		program_regs(settings(0, 16, 2, 2, 20, 40, 30, 200));
		run_utterances(150, 16, 2, 2);

		// Most voiced frames to start and most silent frames to end; the
		// segment is open by the 255th voiced frame at the latest and is left open.
		src_idle_pct = 0;
		snk_stall_pct = 0;
		program_regs(settings(1 << LOUD_SHIFT, 1, 255, 1023, 30, 300, 100, 2000));
		send_frames(TONE_LOUD, 258, 1);
		send_frames(TONE_QUIET, 20, 1);
		send_frames(TONE_LOUD, 10, 1);

		// Random settings in small ranges, one idling pattern per round.
		for (int round = 0; round < 4; round++) begin
			flen = $urandom_range(12, 1);
			start = $urandom_range(5);
			endsil = $urandom_range(6);
			if ($urandom_range(3) == 0)
				thr = $urandom_range(flen << 27);
			else
				thr = longint'(flen) << LOUD_SHIFT;
			case (round)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 81; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 81; end
				default: begin src_idle_pct = 34; snk_stall_pct = 34; end
			endcase
			program_regs(settings(thr, flen, start, endsil, $urandom_range(30),
				$urandom_range(40), $urandom_range(60), $urandom_range(200, 1)));
			run_utterances(150, flen, start, endsil);
		end

		settle();
		if (fail_count == 0 && outstanding == 0) begin
			$display("energy_vad_speech_segmenter regression: pass");
		end else begin
			$display("energy_vad_speech_segmenter regression: fail");
		end
		$finish;
	end

endmodule
